[hw/rtl/ppil_pkg.sv]
`default_nettype none

package ppil_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned EPS_W = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] a_normal_x;
        logic signed [DATA_W-1:0] a_normal_y;
        logic signed [DATA_W-1:0] a_normal_z;
        logic signed [DATA_W-1:0] a_offset;
        logic signed [DATA_W-1:0] b_normal_x;
        logic signed [DATA_W-1:0] b_normal_y;
        logic signed [DATA_W-1:0] b_normal_z;
        logic signed [DATA_W-1:0] b_offset;
    } ppil_in_t;

    typedef struct packed {
        logic                     intersects;
        logic signed [DATA_W-1:0] origin_x;
        logic signed [DATA_W-1:0] origin_y;
        logic signed [DATA_W-1:0] origin_z;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
    } ppil_out_t;

endpackage

`default_nettype wire

[hw/rtl/plane_plane_intersection_line.sv]
`default_nettype none

// Intersection line of two planes n.p + d = 0 in signed fixed point with FRAC_BITS
// fraction bits. Each request gives one result: the direction n1 x n2 and the
// origin c0*n1 + c1*n2, each rounded to nearest (ties away from zero) and saturated
// to 32 bits; when |n1 x n2|^2 is zero or below epsilon << 3*FRAC_BITS, intersects
// is 0 and the origin is zero. The block is a fully pipelined datapath: one request
// can enter every cycle while the skid entry is empty, and its result passes through
// nine arithmetic stages with 32x32 partial products, a 32-stage restoring divider
// for the three origin quotients, one rounding stage and the output register. A
// two-entry output buffer keeps requests flowing while a result waits, until its
// second entry fills. Epsilon is written through the cfg port, which is always ready.
module plane_plane_intersection_line #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire ppil_pkg::ppil_in_t         in_data,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output ppil_pkg::ppil_out_t             out_data,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [ppil_pkg::EPS_W-1:0] cfg_data
);
    import ppil_pkg::*;

    localparam int SQW = 128;             // |n1 x n2|^2
    localparam int KW = 97;               // k0, k1
    localparam int NUMW = 129;            // origin numerators
    localparam int STEPS = 32;            // quotient bits
    localparam int RW = SQW + STEPS + 1;  // divider remainder
    localparam int THR_SHIFT = 3 * FRAC_BITS;
    localparam logic [64:0] HALF = 65'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [STEPS-1:0] q;
        logic neg;
        logic sat;
    } lane_t;

    typedef struct packed {
        logic intersects;
        logic [SQW-1:0] den;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
    } side_t;

    function automatic logic signed [DATA_W-1:0] sat_mag(input logic neg, input logic [64:0] q);
        logic signed [DATA_W-1:0] r;
        if (neg)
        begin
            if (q > 65'h0_8000_0000)
                r = 32'sh8000_0000;
            else
                r = -$signed(q[31:0]);
        end
        else
        begin
            if (q > 65'h0_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else
                r = $signed(q[31:0]);
        end
        return r;
    endfunction

    logic en;
    logic accept;
    logic [EPS_W-1:0] eps_reg;

    assign cfg_ready = 1'b1;
    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EPS_RESET;
        else if (cfg_valid)
            eps_reg <= cfg_data;
    end

    // stage valids: 1..9 arithmetic, 10..41 divider, 42 rounding
    localparam int NV = 9 + STEPS + 1;
    logic [NV:1] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NV-1:1], accept};
    end

    // stage 1: 32x32 products
    logic signed [31:0] s1_a_reg [3];
    logic signed [31:0] s1_b_reg [3];
    logic signed [31:0] s1_da_reg;
    logic signed [31:0] s1_db_reg;
    logic signed [63:0] s1_t_reg [3];
    logic signed [63:0] s1_u_reg [3];
    logic signed [63:0] s1_aa_reg [3];
    logic signed [63:0] s1_bb_reg [3];
    logic signed [63:0] s1_ab_reg [3];
    logic signed [31:0] in_a [3];
    logic signed [31:0] in_b [3];

    assign in_a[0] = in_data.a_normal_x;
    assign in_a[1] = in_data.a_normal_y;
    assign in_a[2] = in_data.a_normal_z;
    assign in_b[0] = in_data.b_normal_x;
    assign in_b[1] = in_data.b_normal_y;
    assign in_b[2] = in_data.b_normal_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_a_reg[i] <= in_a[i];
                s1_b_reg[i] <= in_b[i];
                s1_aa_reg[i] <= in_a[i] * in_a[i];
                s1_bb_reg[i] <= in_b[i] * in_b[i];
                s1_ab_reg[i] <= in_a[i] * in_b[i];
            end
            s1_da_reg <= in_data.a_offset;
            s1_db_reg <= in_data.b_offset;
            s1_t_reg[0] <= in_a[1] * in_b[2];
            s1_u_reg[0] <= in_a[2] * in_b[1];
            s1_t_reg[1] <= in_a[2] * in_b[0];
            s1_u_reg[1] <= in_a[0] * in_b[2];
            s1_t_reg[2] <= in_a[0] * in_b[1];
            s1_u_reg[2] <= in_a[1] * in_b[0];
        end
    end

    // stage 2: cross product and dot products
    logic signed [31:0] s2_a_reg [3];
    logic signed [31:0] s2_b_reg [3];
    logic signed [31:0] s2_da_reg;
    logic signed [31:0] s2_db_reg;
    logic signed [64:0] s2_c_reg [3];
    logic [63:0] s2_n00_reg;
    logic [63:0] s2_n11_reg;
    logic signed [64:0] s2_n01_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_a_reg[i] <= s1_a_reg[i];
                s2_b_reg[i] <= s1_b_reg[i];
                s2_c_reg[i] <= 65'(s1_t_reg[i]) - 65'(s1_u_reg[i]);
            end
            s2_da_reg <= s1_da_reg;
            s2_db_reg <= s1_db_reg;
            s2_n00_reg <= 64'(s1_aa_reg[0]) + 64'(s1_aa_reg[1]) + 64'(s1_aa_reg[2]);
            s2_n11_reg <= 64'(s1_bb_reg[0]) + 64'(s1_bb_reg[1]) + 64'(s1_bb_reg[2]);
            s2_n01_reg <= 65'(s1_ab_reg[0]) + 65'(s1_ab_reg[1]) + 65'(s1_ab_reg[2]);
        end
    end

    // stage 3: magnitudes, partial products, rounded direction
    logic signed [31:0] s3_a_reg [3];
    logic signed [31:0] s3_b_reg [3];
    logic [63:0] s3_ll_reg [3];
    logic [63:0] s3_lh_reg [3];
    logic [63:0] s3_hh_reg [3];
    logic signed [DATA_W-1:0] s3_dir_reg [3];
    logic [63:0] s3_kp_lo_reg [4];
    logic [63:0] s3_kp_hi_reg [4];
    logic [3:0] s3_kneg_reg;
    logic [63:0] c_mag [3];
    logic [64:0] c_abs [3];
    logic [64:0] c_rnd [3];
    logic [64:0] n01_abs;
    logic [32:0] da_abs;
    logic [32:0] db_abs;
    logic [63:0] kx_mag [4];
    logic [31:0] ky_mag [4];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_abs[i] = s2_c_reg[i][64] ? 65'(-s2_c_reg[i]) : 65'(s2_c_reg[i]);
            c_mag[i] = c_abs[i][63:0];
            c_rnd[i] = ({1'b0, c_mag[i]} + HALF) >> FRAC_BITS;
        end
        n01_abs = s2_n01_reg[64] ? 65'(-s2_n01_reg) : 65'(s2_n01_reg);
        da_abs = s2_da_reg[31] ? -{s2_da_reg[31], s2_da_reg} : {1'b0, s2_da_reg};
        db_abs = s2_db_reg[31] ? -{s2_db_reg[31], s2_db_reg} : {1'b0, s2_db_reg};
        // k0 = n01*db - n11*da, k1 = n01*da - n00*db
        kx_mag[0] = n01_abs[63:0];
        ky_mag[0] = db_abs[31:0];
        kx_mag[1] = s2_n11_reg;
        ky_mag[1] = da_abs[31:0];
        kx_mag[2] = n01_abs[63:0];
        ky_mag[2] = da_abs[31:0];
        kx_mag[3] = s2_n00_reg;
        ky_mag[3] = db_abs[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_a_reg[i] <= s2_a_reg[i];
                s3_b_reg[i] <= s2_b_reg[i];
                s3_ll_reg[i] <= c_mag[i][31:0] * c_mag[i][31:0];
                s3_lh_reg[i] <= c_mag[i][31:0] * c_mag[i][63:32];
                s3_hh_reg[i] <= c_mag[i][63:32] * c_mag[i][63:32];
                s3_dir_reg[i] <= sat_mag(s2_c_reg[i][64], c_rnd[i]);
            end
            for (int k = 0; k < 4; k++)
            begin
                s3_kp_lo_reg[k] <= kx_mag[k][31:0] * ky_mag[k];
                s3_kp_hi_reg[k] <= kx_mag[k][63:32] * ky_mag[k];
            end
            s3_kneg_reg[0] <= s2_n01_reg[64] ^ s2_db_reg[31];
            s3_kneg_reg[1] <= s2_da_reg[31];
            s3_kneg_reg[2] <= s2_n01_reg[64] ^ s2_da_reg[31];
            s3_kneg_reg[3] <= s2_db_reg[31];
        end
    end

    // stage 4: assemble squares and k terms
    logic signed [31:0] s4_a_reg [3];
    logic signed [31:0] s4_b_reg [3];
    logic [SQW-1:0] s4_c2_reg [3];
    logic signed [KW-1:0] s4_kt_reg [4];
    logic signed [DATA_W-1:0] s4_dir_reg [3];
    logic [KW-1:0] kt_mag [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            kt_mag[k] = (KW'(s3_kp_hi_reg[k]) << 32) + KW'(s3_kp_lo_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s4_a_reg[i] <= s3_a_reg[i];
                s4_b_reg[i] <= s3_b_reg[i];
                s4_dir_reg[i] <= s3_dir_reg[i];
                s4_c2_reg[i] <= (SQW'(s3_hh_reg[i]) << 64) + (SQW'(s3_lh_reg[i]) << 33)
                    + SQW'(s3_ll_reg[i]);
            end
            for (int k = 0; k < 4; k++)
                s4_kt_reg[k] <= s3_kneg_reg[k] ? $signed(-kt_mag[k]) : $signed(kt_mag[k]);
        end
    end

    // stage 5: squared length, k0 and k1
    logic signed [31:0] s5_a_reg [3];
    logic signed [31:0] s5_b_reg [3];
    logic [SQW-1:0] s5_sq_reg;
    logic signed [KW-1:0] s5_k0_reg;
    logic signed [KW-1:0] s5_k1_reg;
    logic signed [DATA_W-1:0] s5_dir_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_a_reg[i] <= s4_a_reg[i];
                s5_b_reg[i] <= s4_b_reg[i];
                s5_dir_reg[i] <= s4_dir_reg[i];
            end
            s5_sq_reg <= s4_c2_reg[0] + s4_c2_reg[1] + s4_c2_reg[2];
            s5_k0_reg <= s4_kt_reg[0] - s4_kt_reg[1];
            s5_k1_reg <= s4_kt_reg[2] - s4_kt_reg[3];
        end
    end

    // stage 6: threshold test, partial products of a*k0 and b*k1
    logic [SQW-1:0] thr;
    logic [KW-1:0] k0_abs;
    logic [KW-1:0] k1_abs;
    logic [32:0] a_abs [3];
    logic [32:0] b_abs [3];
    logic [63:0] s6_pa_reg [3][3];
    logic [63:0] s6_pb_reg [3][3];
    logic [2:0] s6_na_reg;
    logic [2:0] s6_nb_reg;
    side_t s6_side_reg;

    always_comb
    begin
        thr = SQW'(eps_reg) << THR_SHIFT;
        k0_abs = s5_k0_reg[KW-1] ? KW'(-s5_k0_reg) : KW'(s5_k0_reg);
        k1_abs = s5_k1_reg[KW-1] ? KW'(-s5_k1_reg) : KW'(s5_k1_reg);
        for (int i = 0; i < 3; i++)
        begin
            a_abs[i] = s5_a_reg[i][31] ? -{s5_a_reg[i][31], s5_a_reg[i]} : {1'b0, s5_a_reg[i]};
            b_abs[i] = s5_b_reg[i][31] ? -{s5_b_reg[i][31], s5_b_reg[i]} : {1'b0, s5_b_reg[i]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s6_pa_reg[i][j] <= a_abs[i][31:0] * k0_abs[32*j +: 32];
                    s6_pb_reg[i][j] <= b_abs[i][31:0] * k1_abs[32*j +: 32];
                end
                s6_na_reg[i] <= s5_a_reg[i][31] ^ s5_k0_reg[KW-1];
                s6_nb_reg[i] <= s5_b_reg[i][31] ^ s5_k1_reg[KW-1];
            end
            // zero length never intersects, even with epsilon zero
            s6_side_reg.intersects <= (s5_sq_reg != '0) && (s5_sq_reg >= thr);
            s6_side_reg.den <= s5_sq_reg;
            s6_side_reg.dir_x <= s5_dir_reg[0];
            s6_side_reg.dir_y <= s5_dir_reg[1];
            s6_side_reg.dir_z <= s5_dir_reg[2];
        end
    end

    // stage 7: assemble a*k0 and b*k1
    logic [SQW-1:0] pa_mag [3];
    logic [SQW-1:0] pb_mag [3];
    logic signed [NUMW-1:0] s7_t_reg [3];
    logic signed [NUMW-1:0] s7_u_reg [3];
    side_t s7_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_mag[i] = (SQW'(s6_pa_reg[i][2]) << 64) + (SQW'(s6_pa_reg[i][1]) << 32)
                + SQW'(s6_pa_reg[i][0]);
            pb_mag[i] = (SQW'(s6_pb_reg[i][2]) << 64) + (SQW'(s6_pb_reg[i][1]) << 32)
                + SQW'(s6_pb_reg[i][0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s7_t_reg[i] <= s6_na_reg[i] ? $signed(-{1'b0, pa_mag[i]})
                    : $signed({1'b0, pa_mag[i]});
                s7_u_reg[i] <= s6_nb_reg[i] ? $signed(-{1'b0, pb_mag[i]})
                    : $signed({1'b0, pb_mag[i]});
            end
            s7_side_reg <= s6_side_reg;
        end
    end

    // stage 8: numerators in sign and magnitude
    logic signed [NUMW-1:0] num [3];
    logic [NUMW-1:0] num_abs [3];
    logic [SQW-1:0] s8_mag_reg [3];
    logic [2:0] s8_neg_reg;
    side_t s8_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num[i] = s7_t_reg[i] + s7_u_reg[i];
            num_abs[i] = num[i][NUMW-1] ? NUMW'(-num[i]) : NUMW'(num[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s8_mag_reg[i] <= num_abs[i][SQW-1:0];
                s8_neg_reg[i] <= num[i][NUMW-1];
            end
            s8_side_reg <= s7_side_reg;
        end
    end

    // stage 9 and divider: restoring division, one quotient bit per stage
    lane_t dv_reg [STEPS+1][3];
    side_t dv_side_reg [STEPS+1];
    logic [RW-1:0] den_top;

    assign den_top = RW'(s8_side_reg.den) << STEPS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[0][i].rem <= RW'(s8_mag_reg[i]) << FRAC_BITS;
                dv_reg[0][i].q <= '0;
                dv_reg[0][i].neg <= s8_neg_reg[i];
                // quotient would need more than 32 bits
                dv_reg[0][i].sat <= (RW'(s8_mag_reg[i]) << FRAC_BITS) >= den_top;
            end
            dv_side_reg[0] <= s8_side_reg;
        end
    end

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_div
        logic [RW-1:0] dsh;
        logic [2:0] ge;
        logic [STEPS-1:0] qn [3];

        assign dsh = RW'(dv_side_reg[k-1].den) << (STEPS - k);

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                ge[i] = dv_reg[k-1][i].rem >= dsh;
                qn[i] = dv_reg[k-1][i].q;
                qn[i][STEPS-k] = ge[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dv_reg[k][i].rem <= ge[i] ? dv_reg[k-1][i].rem - dsh : dv_reg[k-1][i].rem;
                    dv_reg[k][i].q <= qn[i];
                    dv_reg[k][i].neg <= dv_reg[k-1][i].neg;
                    dv_reg[k][i].sat <= dv_reg[k-1][i].sat;
                end
                dv_side_reg[k] <= dv_side_reg[k-1];
            end
        end
    end

    // rounding stage
    side_t fs;
    logic [64:0] qr [3];
    logic signed [DATA_W-1:0] org [3];
    ppil_out_t fin_reg;

    assign fs = dv_side_reg[STEPS];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_reg[STEPS][i].sat)
                qr[i] = {1'b1, 64'b0};
            else
                qr[i] = 65'(dv_reg[STEPS][i].q)
                    + 65'({dv_reg[STEPS][i].rem[SQW-1:0], 1'b0} >= {1'b0, fs.den});
            org[i] = fs.intersects ? sat_mag(dv_reg[STEPS][i].neg, qr[i]) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg.intersects <= fs.intersects;
            fin_reg.origin_x <= org[0];
            fin_reg.origin_y <= org[1];
            fin_reg.origin_z <= org[2];
            fin_reg.dir_x <= fs.dir_x;
            fin_reg.dir_y <= fs.dir_y;
            fin_reg.dir_z <= fs.dir_z;
        end
    end

    // output register plus skid entry
    logic take;
    logic o_valid_reg;
    logic s_valid_reg;
    ppil_out_t o_reg;
    ppil_out_t s_reg;

    assign en = !s_valid_reg;
    assign in_ready = en;
    assign take = en && v_reg[NV];
    assign out_valid = o_valid_reg;
    assign out_data = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
        end
        else if (out_ready || !o_valid_reg)
        begin
            if (s_valid_reg)
            begin
                o_valid_reg <= 1'b1;
                s_valid_reg <= 1'b0;
            end
            else
                o_valid_reg <= take;
        end
        else if (take)
            s_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !o_valid_reg)
        begin
            if (s_valid_reg)
                o_reg <= s_reg;
            else if (take)
                o_reg <= fin_reg;
        end
        else if (take)
            s_reg <= fin_reg;
    end

endmodule

`default_nettype wire

[hw/rtl/ppil_checker.sv]
`default_nettype none

module ppil_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire ppil_pkg::ppil_out_t        out_data,
    input wire logic                       cfg_valid,
    input wire logic                       cfg_ready
);
    import ppil_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // no line means no origin
    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.intersects |->
            out_data.origin_x == 0 && out_data.origin_y == 0 && out_data.origin_z == 0)
        else $error("origin not zero without intersection");

    // requests are refused only behind a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("cfg write refused");

endmodule

bind plane_plane_intersection_line ppil_checker u_ppil_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);

`default_nettype wire
